[rtl/core/esutc_pkg.sv]
// shared types, constants and helper functions for the epoch-to-calendar converter
package esutc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BACK,
        ST_FIX,
        ST_LEAP,
        ST_STEP,
        ST_MONTH,
        ST_DONE
    } state_t;

    // constant divisions run on the shared multiplier, in this order
    typedef enum logic [2:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WDAY,
        DIV_YEAR
    } div_t;

    localparam logic [7:0]  EPOCH_YEARS = 8'd70;    // 1970 - 1900
    localparam logic [31:0] EPOCH_WDAY  = 32'd4;    // 1970-01-01 was a thursday
    localparam logic [3:0]  LAST_MONTH  = 4'd11;
    localparam logic [11:0] LEAP_BASE   = 12'd477;  // leap days counted up to 1969
    localparam logic [11:0] YEAR_M1_OFS = 12'd1899; // year - 1 = 1899 + years since 1900

    // floor(2^32 / divisor); the estimate it gives is low by at most one
    function automatic logic [31:0] div_recip(div_t d);
        case (d)
            DIV_SEC:  return 32'd71582788;
            DIV_MIN:  return 32'd71582788;
            DIV_HOUR: return 32'd178956970;
            DIV_WDAY: return 32'd613566756;
            DIV_YEAR: return 32'd11767033;
            default:  return 32'd0;
        endcase
    endfunction

    // divisor for each step
    function automatic logic [8:0] div_const(div_t d);
        case (d)
            DIV_SEC:  return 9'd60;
            DIV_MIN:  return 9'd60;
            DIV_HOUR: return 9'd24;
            DIV_WDAY: return 9'd7;
            DIV_YEAR: return 9'd365;
            default:  return 9'd1;
        endcase
    endfunction

    // month lengths of a common year
    function automatic logic [4:0] month_days(logic [3:0] m);
        case (m)
            4'd0:    return 5'd31;
            4'd1:    return 5'd28;
            4'd2:    return 5'd31;
            4'd3:    return 5'd30;
            4'd4:    return 5'd31;
            4'd5:    return 5'd30;
            4'd6:    return 5'd31;
            4'd7:    return 5'd31;
            4'd8:    return 5'd30;
            4'd9:    return 5'd31;
            4'd10:   return 5'd30;
            4'd11:   return 5'd31;
            default: return 5'd31;
        endcase
    endfunction

    // gregorian leap test on years since 1900 (years 1900 to 2155)
    function automatic logic is_leap(logic [7:0] ys);
        return (ys[1:0] == 2'b00) && (ys != 8'd0) && (ys != 8'd200);
    endfunction

    // leap days between 1970 and the start of the year, for years 1970 to 2155
    function automatic logic [5:0] leap_days(logic [7:0] ys);
        logic [11:0] ym1;
        logic [11:0] lc;
        ym1 = YEAR_M1_OFS + {4'd0, ys};
        // y/4 - y/100 + y/400 with the century terms taken by compares
        lc = (ym1 >> 2)
           - 12'd18 - {11'd0, ys >= 8'd1} - {11'd0, ys >= 8'd101} - {11'd0, ys >= 8'd201}
           + 12'd4 + {11'd0, ys >= 8'd101};
        return 6'(lc - LEAP_BASE);
    endfunction

endpackage

[rtl/core/epoch_seconds_to_utc_date_top.sv]
// epoch seconds to utc calendar date converter, iterative on one shared multiplier
//
//  channel   ports                                   transfer
//  --------  --------------------------------------  ---------------------------------
//  input     start, busy, epoch_seconds              edge with start high and busy low
//  result    done, second, minute, hour,             edge ending the one-cycle done
//            day_of_month, month_index,
//            years_since_1900, weekday
//
// done rises after the input transfer once five constant divisions (states mul, back
// and fix each) on the shared 32x32 multiplier, m month-walk steps (m is the resulting
// month index) and k year step-backs (0 or 1 over the whole input range) are through.
// busy stays high from the input transfer through the done cycle.
// reset clears the sequencer only; the receiver cannot stall, results are never held.
module epoch_seconds_to_utc_date_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_index,
    output logic [7:0]  years_since_1900,
    output logic [2:0]  weekday
);

    esutc_pkg::state_t state_reg, state_next;
    esutc_pkg::div_t   div_reg, div_next;

    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        q_reg, q_next;
    logic [31:0]        prod_reg, prod_next;
    logic [5:0]         second_reg, second_next;
    logic [5:0]         minute_reg, minute_next;
    logic [4:0]         hour_reg, hour_next;
    logic [2:0]         weekday_reg, weekday_next;
    logic [15:0]        days_reg, days_next;
    logic [7:0]         ys_reg, ys_next;
    logic signed [10:0] rem_reg, rem_next;
    logic [3:0]         month_reg, month_next;

    // shared multiplier operands
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;

    // correction of the quotient estimate
    logic [31:0] d32;
    logic [31:0] r_raw;
    logic        r_fix;
    logic [31:0] r_val;
    logic [31:0] q_val;

    // year and month helpers
    logic [7:0]         ys_dec;
    logic [10:0]        step_add;
    logic [4:0]         mlen;
    logic signed [10:0] rem_left;
    logic               month_end;

    // shared multiplier: reciprocal estimate, then back-multiply by the divisor
    always_comb
    begin
        d32 = {23'd0, esutc_pkg::div_const(div_reg)};
        if (state_reg == esutc_pkg::ST_BACK)
        begin
            mul_a = q_reg;
            mul_b = d32;
        end
        else
        begin
            mul_a = acc_reg;
            mul_b = esutc_pkg::div_recip(div_reg);
        end
        product = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // one compare and subtract fixes the estimate
    always_comb
    begin
        r_raw = acc_reg - prod_reg;
        r_fix = (r_raw >= d32);
        r_val = r_fix ? (r_raw - d32) : r_raw;
        q_val = q_reg + {31'd0, r_fix};
    end

    // year step-back and month walk terms
    always_comb
    begin
        ys_dec    = ys_reg - 8'd1;
        step_add  = 11'd365 + {10'd0, esutc_pkg::is_leap(ys_dec)};
        mlen      = esutc_pkg::month_days(month_reg)
                  + {4'd0, (month_reg == 4'd1) && esutc_pkg::is_leap(ys_reg)};
        rem_left  = rem_reg - $signed({6'd0, mlen});
        month_end = (month_reg == esutc_pkg::LAST_MONTH) || rem_left[10];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esutc_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = esutc_pkg::ST_MUL;
            end
            esutc_pkg::ST_MUL:   state_next = esutc_pkg::ST_BACK;
            esutc_pkg::ST_BACK:  state_next = esutc_pkg::ST_FIX;
            esutc_pkg::ST_FIX:
            begin
                if (div_reg == esutc_pkg::DIV_YEAR)
                    state_next = esutc_pkg::ST_LEAP;
                else
                    state_next = esutc_pkg::ST_MUL;
            end
            esutc_pkg::ST_LEAP:  state_next = esutc_pkg::ST_STEP;
            esutc_pkg::ST_STEP:
            begin
                if (!rem_reg[10])
                    state_next = esutc_pkg::ST_MONTH;
            end
            esutc_pkg::ST_MONTH:
            begin
                if (month_end)
                    state_next = esutc_pkg::ST_DONE;
            end
            esutc_pkg::ST_DONE:  state_next = esutc_pkg::ST_IDLE;
            default:             state_next = esutc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            esutc_pkg::ST_IDLE: busy = 1'b0;
            esutc_pkg::ST_DONE: done = 1'b1;
            default:
            begin
                busy = 1'b1;
                done = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        div_next     = div_reg;
        acc_next     = acc_reg;
        q_next       = q_reg;
        prod_next    = prod_reg;
        second_next  = second_reg;
        minute_next  = minute_reg;
        hour_next    = hour_reg;
        weekday_next = weekday_reg;
        days_next    = days_reg;
        ys_next      = ys_reg;
        rem_next     = rem_reg;
        month_next   = month_reg;
        case (state_reg)
            esutc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    acc_next = epoch_seconds;
                    div_next = esutc_pkg::DIV_SEC;
                end
            end
            esutc_pkg::ST_MUL:  q_next = product[63:32];
            esutc_pkg::ST_BACK: prod_next = product[31:0];
            esutc_pkg::ST_FIX:
            begin
                case (div_reg)
                    esutc_pkg::DIV_SEC:
                    begin
                        second_next = r_val[5:0];
                        acc_next    = q_val;
                        div_next    = esutc_pkg::DIV_MIN;
                    end
                    esutc_pkg::DIV_MIN:
                    begin
                        minute_next = r_val[5:0];
                        acc_next    = q_val;
                        div_next    = esutc_pkg::DIV_HOUR;
                    end
                    esutc_pkg::DIV_HOUR:
                    begin
                        hour_next = r_val[4:0];
                        days_next = q_val[15:0];
                        acc_next  = q_val + esutc_pkg::EPOCH_WDAY;
                        div_next  = esutc_pkg::DIV_WDAY;
                    end
                    esutc_pkg::DIV_WDAY:
                    begin
                        weekday_next = r_val[2:0];
                        acc_next     = {16'd0, days_reg};
                        div_next     = esutc_pkg::DIV_YEAR;
                    end
                    esutc_pkg::DIV_YEAR:
                    begin
                        ys_next  = esutc_pkg::EPOCH_YEARS + q_val[7:0];
                        rem_next = $signed({2'b00, r_val[8:0]});
                    end
                    default:
                    begin
                        div_next = esutc_pkg::DIV_SEC;
                    end
                endcase
            end
            esutc_pkg::ST_LEAP:
            begin
                // take out leap days of earlier years
                rem_next   = rem_reg - $signed({5'd0, esutc_pkg::leap_days(ys_reg)});
                month_next = 4'd0;
            end
            esutc_pkg::ST_STEP:
            begin
                // step back one year while the day count is negative
                if (rem_reg[10])
                begin
                    ys_next  = ys_dec;
                    rem_next = rem_reg + $signed(step_add);
                end
            end
            esutc_pkg::ST_MONTH:
            begin
                if (!month_end)
                begin
                    rem_next   = rem_left;
                    month_next = month_reg + 4'd1;
                end
            end
            default:
            begin
                div_next = div_reg;
            end
        endcase
    end

    // sequencer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esutc_pkg::ST_IDLE;
            div_reg   <= esutc_pkg::DIV_SEC;
        end
        else
        begin
            state_reg <= state_next;
            div_reg   <= div_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        q_reg       <= q_next;
        prod_reg    <= prod_next;
        second_reg  <= second_next;
        minute_reg  <= minute_next;
        hour_reg    <= hour_next;
        weekday_reg <= weekday_next;
        days_reg    <= days_next;
        ys_reg      <= ys_next;
        rem_reg     <= rem_next;
        month_reg   <= month_next;
    end

    // result ports
    assign second           = second_reg;
    assign minute           = minute_reg;
    assign hour             = hour_reg;
    assign day_of_month     = rem_reg[4:0] + 5'd1;
    assign month_index      = month_reg;
    assign years_since_1900 = ys_reg;
    assign weekday          = weekday_reg;

`ifndef SYNTH
    // a transfer in starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after input transfer");

    // done only while busy, and for one cycle
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    // time of day fields in range at the result
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
        else $error("time of day out of range");

    // date fields in range at the result
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month_index <= 4'd11) && (day_of_month != 5'd0) && (weekday < 3'd7)
                 && !rem_reg[10])
        else $error("date out of range");
`endif

endmodule

[dv/epoch_seconds_to_utc_date_top_test.sv]
// self-checking testbench for the epoch seconds to utc calendar date converter
`timescale 1ns / 100ps

module epoch_seconds_to_utc_date_top_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned NUM_RANDOM  = 650;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam longint      EPOCH_MAX   = 64'hFFFF_FFFF;

    // one calendar date as the block reports it
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
        logic [2:0] wday;
    } utc_date_t;

    // predicts dates from accepted epoch values and checks results in order
    class date_scoreboard;
        utc_date_t   expected_dates[$];
        logic [31:0] epoch_log[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit leap_year(int y);
            return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
        endfunction

        static function int leaps_through(int y);
            return y / 4 - y / 100 + y / 400;
        endfunction

        static function int month_length(int y, int m);
            case (m)
                1:       return leap_year(y) ? 29 : 28;
                3, 5, 8, 10: return 30;
                default: return 31;
            endcase
        endfunction

        // seconds from the epoch to the first day of a month
        static function longint month_start_secs(int y, int m);
            longint days;
            days = longint'((y - 1970) * 365 + leaps_through(y - 1) - leaps_through(1969));
            for (int i = 0; i < m; i++)
                days += month_length(y, i);
            return days * 86400;
        endfunction

        // epoch seconds to gregorian calendar fields
        static function utc_date_t to_calendar(logic [31:0] t);
            int unsigned total_days;
            int          days;
            int          y;
            int          m;
            utc_date_t   d;
            total_days = t / 32'd86400;
            days = int'(total_days);
            y = 1970 + days / 365;
            days -= (y - 1970) * 365 + leaps_through(y - 1) - leaps_through(1969);
            // estimate may overshoot: step back a year at a time
            while (days < 0)
            begin
                y -= 1;
                days += leap_year(y) ? 366 : 365;
            end
            // month walk stops at december whatever remains
            m = 0;
            while (m < 11 && days >= month_length(y, m))
            begin
                days -= month_length(y, m);
                m += 1;
            end
            d.sec    = 6'(t % 32'd60);
            d.minute = 6'((t / 32'd60) % 32'd60);
            d.hour   = 5'((t / 32'd3600) % 32'd24);
            d.mday   = 5'(days + 1);
            d.mon    = 4'(m);
            d.year   = 8'(y - 1900);
            d.wday   = 3'((total_days + 4) % 7);
            return d;
        endfunction

        function void note_input(logic [31:0] t);
            expected_dates.push_back(to_calendar(t));
            epoch_log.push_back(t);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(utc_date_t got);
            utc_date_t   want;
            logic [31:0] t;
            if (expected_dates.size() == 0)
            begin
                report("result strobe with no transfer outstanding");
                return;
            end
            want = expected_dates.pop_front();
            t = epoch_log.pop_front();
            if (got.sec !== want.sec)
                report($sformatf("epoch %0d second %0d want %0d", t, got.sec, want.sec));
            if (got.minute !== want.minute)
                report($sformatf("epoch %0d minute %0d want %0d", t, got.minute, want.minute));
            if (got.hour !== want.hour)
                report($sformatf("epoch %0d hour %0d want %0d", t, got.hour, want.hour));
            if (got.mday !== want.mday)
                report($sformatf("epoch %0d day_of_month %0d want %0d", t, got.mday, want.mday));
            if (got.mon !== want.mon)
                report($sformatf("epoch %0d month_index %0d want %0d", t, got.mon, want.mon));
            if (got.year !== want.year)
                report($sformatf("epoch %0d years_since_1900 %0d want %0d",
                                 t, got.year, want.year));
            if (got.wday !== want.wday)
                report($sformatf("epoch %0d weekday %0d want %0d", t, got.wday, want.wday));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] epoch_seconds = 32'd0;
    logic        busy;
    logic        done;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [7:0]  years_since_1900;
    logic [2:0]  weekday;

    date_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    bit             burst_mode = 1'b0;

    epoch_seconds_to_utc_date_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .years_since_1900 (years_since_1900),
        .weekday          (weekday)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result transfers, one cycle each
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({second, minute, hour, day_of_month, month_index,
                             years_since_1900, weekday});
    end

    // mostly short gaps, a few long ones, none during bursts
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // clamp a computed epoch into the 32-bit input range
    function automatic logic [31:0] clamp_epoch(longint s);
        if (s < 0)
            return 32'd0;
        if (s > EPOCH_MAX)
            return 32'hFFFF_FFFF;
        return s[31:0];
    endfunction

    // random epoch: raw words, year starts, month starts and day edges
    function automatic logic [31:0] pick_epoch();
        int     y;
        longint ofs;
        case ($urandom_range(0, 3))
            0, 1:
                return $urandom();
            2:
            begin
                y = $urandom_range(1971, 2106);
                ofs = longint'($urandom_range(0, 345600)) - 172800;
                return clamp_epoch(date_scoreboard::month_start_secs(y, 0) + ofs);
            end
            default:
            begin
                y = $urandom_range(1970, 2106);
                case ($urandom_range(0, 3))
                    0:       ofs = 0;
                    1:       ofs = -1;
                    2:       ofs = 86399;
                    default: ofs = longint'($urandom_range(0, 172800)) - 86400;
                endcase
                return clamp_epoch(date_scoreboard::month_start_secs(y,
                                   $urandom_range(0, 11)) + ofs);
            end
        endcase
    endfunction

    // one input transfer after an idle gap; start stays high between back-to-back items
    task automatic send_item(logic [31:0] t, int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        epoch_seconds <= t;
        do
            @(posedge clk);
        while (busy);
        sb.note_input(t);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    logic [31:0] directed[$] = '{
        32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399, 32'd94694400,
        32'd951782400, 32'd951868800, 32'd2147483647, 32'd2147483648,
        32'd4102444799, 32'd4102444800, 32'd4107456000, 32'd4107542400,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd4291747199, 32'd4291747200
    };

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, year and leap edges, december, last second
        foreach (directed[i])
            send_item(directed[i], pick_gap());
        drain();

        // random, in blocks that each pick their idle pattern at random
        for (int unsigned n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (n % 150 == 149)
                drain();
            send_item(pick_epoch(), pick_gap());
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/esutc_pkg.sv
rtl/core/epoch_seconds_to_utc_date_top.sv
dv/epoch_seconds_to_utc_date_top_test.sv
